### rtl/rbfc_pkg.sv
// Package for the RBF network classifier: link structs, codes, exp table
// and the saturating add helper. No dependencies.
package rbfc_pkg;

    localparam int NIDX_W  = 8;    // neuron index width on links (up to 256)
    localparam int CAT_W   = 4;    // category width on links (up to 16)
    localparam logic [15:0] LOG2E_Q15 = 16'd47274;

    typedef enum logic [1:0] {
        FUNC_CENTER   = 2'd0,
        FUNC_WEIGHT   = 2'd1,
        FUNC_BIAS     = 2'd2,
        FUNC_CLASSIFY = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Activation word passed from cell to cell
    typedef struct packed {
        logic              vld;
        logic              fin;
        logic [NIDX_W-1:0] nidx;
        logic [15:0]       act;
    } link_t;

    // Running best passed down the row after the last neuron
    typedef struct packed {
        logic              vld;
        logic [CAT_W-1:0]  cat;
        logic [31:0]       score;
    } best_t;

    // round(2^(-k/16) * 65536), k = 0..16
    function automatic logic [16:0] pow2_neg(input logic [4:0] k);
        logic [16:0] p;
        begin
            case (k)
                5'd0:    p = 17'd65536;
                5'd1:    p = 17'd62757;
                5'd2:    p = 17'd60097;
                5'd3:    p = 17'd57549;
                5'd4:    p = 17'd55109;
                5'd5:    p = 17'd52773;
                5'd6:    p = 17'd50535;
                5'd7:    p = 17'd48393;
                5'd8:    p = 17'd46341;
                5'd9:    p = 17'd44376;
                5'd10:   p = 17'd42495;
                5'd11:   p = 17'd40693;
                5'd12:   p = 17'd38968;
                5'd13:   p = 17'd37316;
                5'd14:   p = 17'd35734;
                5'd15:   p = 17'd34219;
                5'd16:   p = 17'd32768;
                default: p = 17'd32768;
            endcase
            return p;
        end
    endfunction

    // clamp a 34-bit signed sum to 32 bits
    function automatic logic [31:0] sat32(input logic signed [33:0] v);
        logic [31:0] r;
        begin
            if (v > 34'sh0_7FFF_FFFF)
                r = 32'h7FFF_FFFF;
            else if (v < -34'sh0_8000_0000)
                r = 32'h8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

### rtl/rbf_network_classifier_core.sv
// Top level of the RBF network classifier: command control, neuron
// issue counter, activation pipeline and the row of category cells.
// Depends on rbfc_pkg, rbfc_act, rbfc_cell.
//
// Usage:
//  - Drive func, neuron_index, class_index, x_coord, y_coord and value with
//    start high; the word is taken at a clock edge where busy is low.
//  - func center/weight/bias writes keep busy low and return nothing. Writes
//    to indexes past the configured sizes are dropped.
//  - A classify word raises busy. The neuron counter issues one neuron per
//    cycle into a 7-stage activation pipeline; each activation then walks
//    the row of category cells, one cell per cycle, where it is weighted and
//    added to that category's sum. A finish token follows the last neuron,
//    adds the bias in each cell, and carries the running best down the row.
//  - busy drops the cycle after done, so a new word can be taken from
//    that cycle on.
//  - done pulses for one cycle with best_category and best_score; the
//    receiver cannot stall, so it must take the word in that cycle.
//  - Reset clears control state and all stored centers, scales, weights
//    and biases read as zero until written.
module rbf_network_classifier_core #(
    parameter int NEURONS    = 16,
    parameter int CATEGORIES = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [3:0]         neuron_index,
    input  logic [1:0]         class_index,
    input  logic signed [15:0] x_coord,
    input  logic signed [15:0] y_coord,
    input  logic signed [15:0] value,
    output logic               done,
    output logic [1:0]         best_category,
    output logic signed [31:0] best_score
);
    localparam int NW = NEURONS > 1 ? $clog2(NEURONS) : 1;
    localparam int CW = NW + 1;

    rbfc_pkg::state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   px_reg, py_reg;

    logic          accept, do_cls, n_ok, c_ok, clr;
    logic [NW-1:0] waddr;
    rbfc_pkg::link_t iss, act_out;
    rbfc_pkg::link_t lnk [CATEGORIES+1];
    rbfc_pkg::best_t bst [CATEGORIES+1];

    assign accept = start && !busy;
    assign do_cls = accept && (func == rbfc_pkg::FUNC_CLASSIFY);
    assign n_ok   = int'(neuron_index) < NEURONS;
    assign c_ok   = int'(class_index) < CATEGORIES;
    assign waddr  = NW'(neuron_index);
    assign clr    = do_cls;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbfc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_cls)
        begin
            px_reg <= x_coord;
            py_reg <= y_coord;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        iss        = '0;
        busy       = 1'b1;
        case (state_reg)
            rbfc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (do_cls)
                begin
                    state_next = rbfc_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            rbfc_pkg::ST_RUN:
            begin
                iss.nidx = rbfc_pkg::NIDX_W'(cnt_reg);
                if (cnt_reg == CW'(NEURONS))
                begin
                    iss.fin    = 1'b1;
                    state_next = rbfc_pkg::ST_DRAIN;
                end
                else
                begin
                    iss.vld  = 1'b1;
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rbfc_pkg::ST_DRAIN:
            begin
                if (bst[CATEGORIES].vld)
                    state_next = rbfc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rbfc_pkg::ST_IDLE;
            end
        endcase
    end

    rbfc_act #(
        .NEURONS (NEURONS)
    ) u_act (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && func == rbfc_pkg::FUNC_CENTER && n_ok),
        .wr_addr (waddr),
        .wr_cx   (x_coord),
        .wr_cy   (y_coord),
        .wr_sc   (value),
        .iss     (iss),
        .px      (px_reg),
        .py      (py_reg),
        .lout    (act_out)
    );

    assign lnk[0] = act_out;
    assign bst[0] = '0;

    for (genvar c = 0; c < CATEGORIES; c++)
    begin : g_cell
        rbfc_cell #(
            .NEURONS (NEURONS),
            .IDX     (c)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .clr    (clr),
            .w_we   (accept && func == rbfc_pkg::FUNC_WEIGHT && n_ok && c_ok
                     && int'(class_index) == c),
            .w_addr (waddr),
            .w_data (value),
            .b_we   (accept && func == rbfc_pkg::FUNC_BIAS && c_ok
                     && int'(class_index) == c),
            .b_data (value),
            .lin    (lnk[c]),
            .lout   (lnk[c+1]),
            .bin    (bst[c]),
            .bout   (bst[c+1])
        );
    end

    assign done          = bst[CATEGORIES].vld;
    assign best_category = bst[CATEGORIES].cat[1:0];
    assign best_score    = bst[CATEGORIES].score;

    ap_done_drain: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> state_reg == rbfc_pkg::ST_DRAIN)
        else $error("result outside drain");
    ap_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> state_reg == rbfc_pkg::ST_IDLE)
        else $error("no return to idle after result");
    ap_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        do_cls |=> state_reg == rbfc_pkg::ST_RUN && cnt_reg == '0)
        else $error("classify not started");
    ap_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !busy |-> !iss.vld && !iss.fin)
        else $error("neuron issued while idle");

endmodule

### rtl/rbfc_act.sv
// Neuron store (centers, scales) and the activation pipeline exp(-d2*s).
// Depends on rbfc_pkg.
module rbfc_act #(
    parameter int NEURONS = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [(NEURONS>1 ? $clog2(NEURONS) : 1)-1:0] wr_addr,
    input  logic [15:0]            wr_cx,
    input  logic [15:0]            wr_cy,
    input  logic [15:0]            wr_sc,
    input  rbfc_pkg::link_t        iss,
    input  logic [15:0]            px,
    input  logic [15:0]            py,
    output rbfc_pkg::link_t        lout
);
    localparam int NW = NEURONS > 1 ? $clog2(NEURONS) : 1;
    localparam int ST = 7;

    logic [15:0] cx_mem [NEURONS];
    logic [15:0] cy_mem [NEURONS];
    logic [15:0] sc_mem [NEURONS];
    logic [NEURONS-1:0] nv_reg;

    logic [ST:1] pv_reg, pf_reg;
    logic [rbfc_pkg::NIDX_W-1:0] pn_reg [ST:1];

    logic [15:0] cx1_reg, cy1_reg, sc1_reg;
    logic        ok1_reg;
    logic [32:0] dxx2_reg, dyy2_reg;
    logic [14:0] sc2_reg, sc3_reg;
    logic [33:0] d2_reg;
    logic [32:0] t_reg;
    logic [33:0] u_reg;
    logic [16:0] m_reg;
    logic [4:0]  sh_reg;
    logic        big_reg;
    logic [15:0] a_reg;

    logic signed [16:0] dx, dy;
    logic signed [33:0] sqx, sqy;
    logic [15:0] cxe, cye, sce;
    logic [48:0] tp, up;
    logic [17:0] hi;
    logic [16:0] pk, pk1, diff, shv;
    logic [23:0] dr;
    logic [NW-1:0] raddr;

    assign raddr = iss.nidx[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nv_reg <= '0;
        else if (wr_en)
            nv_reg[wr_addr] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            cx_mem[wr_addr] <= wr_cx;
            cy_mem[wr_addr] <= wr_cy;
            sc_mem[wr_addr] <= wr_sc;
        end
        cx1_reg <= cx_mem[raddr];
        cy1_reg <= cy_mem[raddr];
        sc1_reg <= sc_mem[raddr];
        ok1_reg <= nv_reg[raddr];
    end

    // stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg <= '0;
            pf_reg <= '0;
        end
        else
        begin
            pv_reg <= {pv_reg[ST-1:1], iss.vld};
            pf_reg <= {pf_reg[ST-1:1], iss.fin};
        end
    end

    always_ff @(posedge clk)
    begin
        pn_reg[1] <= iss.nidx;
        for (int i = 2; i <= ST; i++)
            pn_reg[i] <= pn_reg[i-1];
    end

    always_comb
    begin
        cxe  = ok1_reg ? cx1_reg : 16'd0;
        cye  = ok1_reg ? cy1_reg : 16'd0;
        sce  = ok1_reg ? sc1_reg : 16'd0;
        dx   = $signed({px[15], px}) - $signed({cxe[15], cxe});
        dy   = $signed({py[15], py}) - $signed({cye[15], cye});
        sqx  = dx * dx;
        sqy  = dy * dy;
        tp   = d2_reg * {19'd0, sc3_reg};
        up   = {16'd0, t_reg} * {33'd0, rbfc_pkg::LOG2E_Q15};
        hi   = u_reg[33:16];
        pk   = rbfc_pkg::pow2_neg({1'b0, u_reg[15:12]});
        pk1  = rbfc_pkg::pow2_neg({1'b0, u_reg[15:12]} + 5'd1);
        diff = pk - pk1;
        dr   = diff[11:0] * u_reg[11:0];
        shv  = m_reg >> sh_reg;
    end

    // datapath: squares, sum, scale, log2e, table, shift
    always_ff @(posedge clk)
    begin
        dxx2_reg <= sqx[32:0];
        dyy2_reg <= sqy[32:0];
        sc2_reg  <= sce[15] ? 15'd0 : sce[14:0];
        d2_reg   <= {1'b0, dxx2_reg} + {1'b0, dyy2_reg};
        sc3_reg  <= sc2_reg;
        t_reg    <= tp[48:16];
        u_reg    <= up[48:15];
        big_reg  <= (hi >= 18'd17);
        sh_reg   <= hi[4:0];
        m_reg    <= pk - {5'd0, dr[23:12]};
        if (big_reg)
            a_reg <= 16'd0;
        else if (shv[16])
            a_reg <= 16'hFFFF;
        else
            a_reg <= shv[15:0];
    end

    assign lout.vld  = pv_reg[ST];
    assign lout.fin  = pf_reg[ST];
    assign lout.nidx = pn_reg[ST];
    assign lout.act  = a_reg;

endmodule

### rtl/rbfc_cell.sv
// One category cell: weight column, bias, accumulator and a step of the
// argmax. Passes activations and the running best to its neighbor.
// Depends on rbfc_pkg.
module rbfc_cell #(
    parameter int NEURONS = 16,
    parameter int IDX     = 0
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   clr,
    input  logic                   w_we,
    input  logic [(NEURONS>1 ? $clog2(NEURONS) : 1)-1:0] w_addr,
    input  logic [15:0]            w_data,
    input  logic                   b_we,
    input  logic [15:0]            b_data,
    input  rbfc_pkg::link_t        lin,
    output rbfc_pkg::link_t        lout,
    input  rbfc_pkg::best_t        bin,
    output rbfc_pkg::best_t        bout
);
    localparam int NW = NEURONS > 1 ? $clog2(NEURONS) : 1;

    logic [15:0] w_mem [NEURONS];
    logic [NEURONS-1:0] wv_reg;
    logic [15:0] w1_reg, bias_reg;
    logic        wv1_reg;
    rbfc_pkg::link_t l1_reg;
    logic signed [32:0] prod_reg;
    logic        v2_reg, f2_reg, f3_reg;
    logic [31:0] acc_reg;
    rbfc_pkg::best_t best_reg;

    logic signed [15:0] wsel;
    logic signed [33:0] sum_p, sum_b;
    logic        take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv_reg   <= '0;
            bias_reg <= '0;
        end
        else
        begin
            if (w_we)
                wv_reg[w_addr] <= 1'b1;
            if (b_we)
                bias_reg <= b_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_addr] <= w_data;
        w1_reg  <= w_mem[lin.nidx[NW-1:0]];
        wv1_reg <= wv_reg[lin.nidx[NW-1:0]];
    end

    assign wsel  = wv1_reg ? $signed(w1_reg) : 16'sd0;
    assign sum_p = $signed({{2{acc_reg[31]}}, acc_reg}) + $signed({prod_reg[32], prod_reg});
    assign sum_b = $signed({{2{acc_reg[31]}}, acc_reg})
                 + $signed({{2{bias_reg[15]}}, bias_reg, 16'd0});
    assign take  = (IDX == 0) || ($signed(acc_reg) > $signed(bin.score));

    always_ff @(posedge clk)
    begin
        prod_reg <= wsel * $signed({1'b0, l1_reg.act});
        if (clr)
            acc_reg <= '0;
        else if (v2_reg)
            acc_reg <= rbfc_pkg::sat32(sum_p);
        else if (f2_reg)
            acc_reg <= rbfc_pkg::sat32(sum_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            l1_reg   <= '0;
            v2_reg   <= 1'b0;
            f2_reg   <= 1'b0;
            f3_reg   <= 1'b0;
            best_reg <= '0;
        end
        else
        begin
            l1_reg       <= lin;
            v2_reg       <= l1_reg.vld;
            f2_reg       <= l1_reg.fin;
            f3_reg       <= f2_reg;
            best_reg.vld <= f3_reg;
            if (f3_reg)
            begin
                best_reg.cat   <= take ? rbfc_pkg::CAT_W'(IDX) : bin.cat;
                best_reg.score <= take ? acc_reg : bin.score;
            end
        end
    end

    assign lout = l1_reg;
    assign bout = best_reg;

    ap_one_fin: assert property (@(posedge clk) disable iff (!rst_n)
        f3_reg |-> !f2_reg)
        else $error("cell saw back-to-back finish tokens");
    ap_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> !f2_reg)
        else $error("cell saw data and finish together");
    ap_best: assert property (@(posedge clk) disable iff (!rst_n)
        f3_reg |=> best_reg.vld)
        else $error("cell best word not produced");

endmodule
